// File: design/bpof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpof_pkg
// shared constants and types of the box pair overlap finder
// ----------------------------------------------------------------------------
package bpof_pkg;

  localparam int MAX_BOXES   = 64;   // store capacity, 2 to 64
  localparam int COORD_WIDTH = 32;   // coordinate bits kept, 8 to 32
  localparam int QUEUE_DEPTH = 2;    // request queue between front and back

  localparam int IDX_W     = (MAX_BOXES > 2) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int OUT_IDX_W = 6;      // fixed width of the index ports
  localparam int IN_W      = 32;     // fixed width of the coordinate ports
  localparam int QPTR_W    = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // one classified request: either a box to scan and store, or an overflow
  typedef struct packed {
    logic ovf;
    idx_t idx;
    box_t box;
  } cmd_t;

endpackage

// File: design/box_pair_overlap_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_pair_overlap_finder
// all-pairs axis-aligned box overlap test over a set of up to 64 boxes
// ----------------------------------------------------------------------------
//
//  channel  handshake           payload
//  -------  ------------------  ---------------------------------------------
//  in       in_valid/in_stall   start_set, min_x/y/z, max_x/y/z (Q16.16)
//  out      out_valid/out_stall lower_index, upper_index, overflow, last_of_run
//
//  a box with index k is compared against the k boxes stored before it:
//  the single read port of the box store is walked one stored box per cycle
//  while out_stall does not hold a result; up to two requests queue ahead
//  out_stall pauses the scan in place; in_stall rises only when the queue is full
//  rst clears the box count, the queue and the scan engine; the store is not
//  cleared and needs no clearing pass, as only entries of the current set are read
//
module box_pair_overlap_finder (
  input  logic                 clk,
  input  logic                 rst,
  // box requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 start_set,
  input  logic signed [31:0]   min_x,
  input  logic signed [31:0]   min_y,
  input  logic signed [31:0]   min_z,
  input  logic signed [31:0]   max_x,
  input  logic signed [31:0]   max_y,
  input  logic signed [31:0]   max_z,
  // overlap results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [5:0]           lower_index,
  output logic [5:0]           upper_index,
  output logic                 overflow,
  output logic                 last_of_run
);

  // front to queue
  logic           q_full;
  logic           q_push;
  bpof_pkg::cmd_t q_in_cmd;
  // queue to scan engine
  logic           q_valid;
  logic           q_pop;
  bpof_pkg::cmd_t q_out_cmd;

  // front: numbers each box within its set and flags a full store
  bpof_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_set (start_set),
    .min_x     (min_x),
    .min_y     (min_y),
    .min_z     (min_z),
    .max_x     (max_x),
    .max_y     (max_y),
    .max_z     (max_z),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd)
  );

  // decouples request intake from the scan, so each side stalls on its own
  bpof_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_out_cmd)
  );

  // back: stores the box, scans earlier boxes in index order, emits pairs or overflow
  bpof_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cmd       (q_out_cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .lower_index (lower_index),
    .upper_index (upper_index),
    .overflow    (overflow),
    .last_of_run (last_of_run)
  );

endmodule

// File: design/bpof_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpof_front
// accepts boxes, numbers them within the set and flags store overflow
// ----------------------------------------------------------------------------
module bpof_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      start_set,
  input  logic signed [31:0]        min_x,
  input  logic signed [31:0]        min_y,
  input  logic signed [31:0]        min_z,
  input  logic signed [31:0]        max_x,
  input  logic signed [31:0]        max_y,
  input  logic signed [31:0]        max_z,
  input  logic                      q_full,
  output logic                      q_push,
  output bpof_pkg::cmd_t            q_cmd
);

  bpof_pkg::cnt_t box_count;
  bpof_pkg::cnt_t box_count_next;
  bpof_pkg::cnt_t base;
  logic           full;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    base = start_set ? '0 : box_count;
    full = (base == bpof_pkg::cnt_t'(bpof_pkg::MAX_BOXES));
    box_count_next = full ? base : base + bpof_pkg::cnt_t'(1);

    q_cmd.ovf       = full;
    q_cmd.idx       = base[bpof_pkg::IDX_W-1:0];
    // only the low coordinate bits are kept, read as two's complement
    q_cmd.box.min_x = min_x[bpof_pkg::COORD_WIDTH-1:0];
    q_cmd.box.min_y = min_y[bpof_pkg::COORD_WIDTH-1:0];
    q_cmd.box.min_z = min_z[bpof_pkg::COORD_WIDTH-1:0];
    q_cmd.box.max_x = max_x[bpof_pkg::COORD_WIDTH-1:0];
    q_cmd.box.max_y = max_y[bpof_pkg::COORD_WIDTH-1:0];
    q_cmd.box.max_z = max_z[bpof_pkg::COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
    end else if (q_push) begin
      box_count <= box_count_next;
    end
  end

endmodule

// File: design/bpof_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpof_queue
// short request queue between the front and the scan engine
// ----------------------------------------------------------------------------
module bpof_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bpof_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop,
  output bpof_pkg::cmd_t pop_cmd
);

  bpof_pkg::cmd_t                  slots [bpof_pkg::QUEUE_DEPTH];
  logic [bpof_pkg::QPTR_W-1:0]     wr_ptr;
  logic [bpof_pkg::QPTR_W-1:0]     rd_ptr;
  logic [bpof_pkg::QCNT_W-1:0]     count;
  logic                            do_pop;

  assign full      = (count == bpof_pkg::QCNT_W'(bpof_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign do_pop    = pop && pop_valid;
  assign pop_cmd   = slots[rd_ptr];

  function automatic logic [bpof_pkg::QPTR_W-1:0] ptr_inc(
    input logic [bpof_pkg::QPTR_W-1:0] p
  );
    ptr_inc = (p == bpof_pkg::QPTR_W'(bpof_pkg::QUEUE_DEPTH - 1)) ?
              '0 : p + bpof_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr        <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !do_pop) begin
        count <= count + bpof_pkg::QCNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - bpof_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/bpof_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpof_back
// scan engine: box store, one compare per cycle unless out_stall holds a result, result register
// ----------------------------------------------------------------------------
module bpof_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  bpof_pkg::cmd_t                       q_cmd,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bpof_pkg::OUT_IDX_W-1:0]       lower_index,
  output logic [bpof_pkg::OUT_IDX_W-1:0]       upper_index,
  output logic                                 overflow,
  output logic                                 last_of_run
);

  bpof_pkg::box_t store [bpof_pkg::MAX_BOXES];

  logic           busy;
  bpof_pkg::cmd_t cur;
  bpof_pkg::idx_t rd_idx;
  logic           rvalid;
  bpof_pkg::idx_t rtag;
  bpof_pkg::box_t rdata;
  logic           pend_valid;
  bpof_pkg::idx_t pend_idx;

  logic adv;
  logic issue;
  logic hit;
  logic scan_done;

  // all four bound orderings: matches max of minima <= min of maxima
  function automatic logic axis_ok(
    input bpof_pkg::coord_t amin, input bpof_pkg::coord_t amax,
    input bpof_pkg::coord_t bmin, input bpof_pkg::coord_t bmax
  );
    axis_ok = (amin <= amax) && (amin <= bmax) && (bmin <= amax) && (bmin <= bmax);
  endfunction

  always_comb begin
    adv       = !out_valid || !out_stall;
    q_pop     = q_valid && !busy;
    issue     = busy && !cur.ovf && (rd_idx != cur.idx) && adv;
    scan_done = busy && !cur.ovf && (rd_idx == cur.idx) && !rvalid;
    hit = axis_ok(rdata.min_x, rdata.max_x, cur.box.min_x, cur.box.max_x) &&
          axis_ok(rdata.min_y, rdata.max_y, cur.box.min_y, cur.box.max_y) &&
          axis_ok(rdata.min_z, rdata.max_z, cur.box.min_z, cur.box.max_z);
  end

  // box store: write on request entry, registered read during the scan
  always_ff @(posedge clk) begin
    if (q_pop && !q_cmd.ovf) begin
      store[q_cmd.idx] <= q_cmd.box;
    end
    if (issue) begin
      rdata <= store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      rvalid     <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy       <= 1'b1;
        cur        <= q_cmd;
        rd_idx     <= '0;
        rvalid     <= 1'b0;
        pend_valid <= 1'b0;
      end else if (busy && adv) begin
        rvalid <= issue;
        if (issue) begin
          rd_idx <= rd_idx + bpof_pkg::IDX_W'(1);
          rtag   <= rd_idx;
        end
        if (cur.ovf) begin
          out_valid   <= 1'b1;
          lower_index <= '0;
          upper_index <= '0;
          overflow    <= 1'b1;
          last_of_run <= 1'b1;
          busy        <= 1'b0;
        end else if (rvalid && hit) begin
          // hold the newest hit back until we know whether it is the last
          pend_valid <= 1'b1;
          pend_idx   <= rtag;
          if (pend_valid) begin
            out_valid   <= 1'b1;
            lower_index <= bpof_pkg::OUT_IDX_W'(pend_idx);
            upper_index <= bpof_pkg::OUT_IDX_W'(cur.idx);
            overflow    <= 1'b0;
            last_of_run <= 1'b0;
          end
        end else if (scan_done) begin
          busy       <= 1'b0;
          pend_valid <= 1'b0;
          if (pend_valid) begin
            out_valid   <= 1'b1;
            lower_index <= bpof_pkg::OUT_IDX_W'(pend_idx);
            upper_index <= bpof_pkg::OUT_IDX_W'(cur.idx);
            overflow    <= 1'b0;
            last_of_run <= 1'b1;
          end
        end
      end
    end
  end

  a_ovf_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> lower_index == '0 && upper_index == '0 && last_of_run)
    else $error("overflow result with non-zero indices or not last");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overflow |-> lower_index < upper_index)
    else $error("pair lower index not below upper index");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> rd_idx < cur.idx)
    else $error("store read at or above the new box index");

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> busy)
    else $error("held hit outside an active scan");

endmodule
